FILE: src/pcwpc_pkg.sv
// Shared constants and types for the pedal cadence and wheel pulse counter.
// No dependencies.
package pcwpc_pkg;

    localparam int unsigned PRESCALE_W = 16;
    localparam int unsigned WINDOW_W   = 8;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS   = 1'd1;

    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 16'd1000;
    localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 8'd50;

    typedef logic [PRESCALE_W-1:0] t_time;
    typedef logic [COUNT_W-1:0]    t_count;

endpackage

FILE: src/pedal_cadence_and_wheel_pulse_counter_top.sv
// Top level of the pedal cadence and wheel pulse counter.
// Depends on pcwpc_pkg for widths, register indexes and reset values.
//
// Usage:
//   The input channel carries one sensor sample per beat: the pedal level,
//   the hall level and a tick flag. It is accepted at a rising edge where
//   i_in_valid is high and o_in_stall is low. Every accepted sample yields
//   exactly one result beat on the output channel, accepted where
//   o_out_valid is high and i_out_stall is low.
//   The sample updates the counter state and loads the output register
//   at the same edge, so the result is visible the cycle after acceptance.
//   Throughput is one sample per cycle while the receiver does not stall;
//   the state update is combinational: 16- and 8-bit increments and compares.
//   When the receiver stalls, the output register holds its beat and
//   o_in_stall rises, so no further sample is taken until the beat leaves.
//   A beat taken in the same cycle frees the register for the next sample.
//   Reset (i_rst_n low, synchronous) clears all counters and latched results,
//   empties the output register and loads prescale_limit with 1000 and
//   window_ticks with 50. Configuration writes go through i_cfg_we,
//   i_cfg_index and i_cfg_data and take effect at the next edge; they are
//   meant to happen only while the block is idle.
module pedal_cadence_and_wheel_pulse_counter_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pcwpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcwpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_pedal_level,
    input  logic                            i_hall_level,
    input  logic                            i_tick,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pcwpc_pkg::COUNT_W-1:0]    o_pedal_result,
    output logic [pcwpc_pkg::COUNT_W-1:0]    o_wheel_result,
    output logic                            o_window_done
);
    import pcwpc_pkg::*;

    // Configuration registers.
    t_time                r_prescale_limit;
    logic [WINDOW_W-1:0]  r_window_ticks;

    // Sample-to-sample state.
    t_time  r_fine_count,  n_fine_count;
    t_time  r_coarse_count, n_coarse_count;
    t_time  r_low_time,    n_low_time;
    t_time  r_high_time,   n_high_time;
    logic   r_pedal_prev;
    logic   r_hall_prev;
    t_count r_pedal_run,   n_pedal_run;
    t_count r_wheel_run,   n_wheel_run;
    t_count r_tick_count,  n_tick_count;
    t_count r_pedal_latched, n_pedal_latched;
    t_count r_wheel_latched, n_wheel_latched;
    logic   n_done;

    // Output register.
    logic   r_out_valid;
    logic   r_done;

    logic   w_accept;
    t_time  w_fine_inc;
    t_time  w_coarse_step;
    t_count w_run_base;
    t_count w_tick_inc;

    // The output register can take a new beat when it is empty or its
    // current beat leaves in this cycle.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    always_comb begin
        // Time base: the fine counter wraps past the limit and steps coarse.
        w_fine_inc    = r_fine_count + 16'd1;
        n_fine_count  = w_fine_inc;
        w_coarse_step = r_coarse_count;
        if (w_fine_inc > r_prescale_limit) begin
            n_fine_count  = '0;
            w_coarse_step = r_coarse_count + 16'd1;
        end
        n_coarse_count = w_coarse_step;

        // A pedal edge records the elapsed coarse time as low or high time,
        // restarts the time base and scores the cycle.
        n_low_time  = r_low_time;
        n_high_time = r_high_time;
        n_pedal_run = r_pedal_run;
        if (i_pedal_level != r_pedal_prev) begin
            if (i_pedal_level) begin
                n_low_time = w_coarse_step;
            end else begin
                n_high_time = w_coarse_step;
            end
            n_fine_count   = '0;
            n_coarse_count = '0;
            if (n_high_time >= n_low_time) begin
                n_pedal_run = r_pedal_run + 8'd1;
            end else begin
                n_pedal_run = '0;
            end
        end

        n_wheel_run = r_wheel_run;
        if (i_hall_level && !r_hall_prev) begin
            n_wheel_run = r_wheel_run + 8'd1;
        end

        // The window closes on the tick that brings the count to the limit;
        // it is applied after this sample's edges have been counted.
        w_run_base      = '0;
        w_tick_inc      = r_tick_count + 8'd1;
        n_tick_count    = r_tick_count;
        n_pedal_latched = r_pedal_latched;
        n_wheel_latched = r_wheel_latched;
        n_done          = 1'b0;
        if (i_tick) begin
            n_tick_count = w_tick_inc;
            if (w_tick_inc >= r_window_ticks) begin
                n_pedal_latched = n_pedal_run;
                n_wheel_latched = n_wheel_run;
                n_tick_count    = w_run_base;
                n_pedal_run     = w_run_base;
                n_wheel_run     = w_run_base;
                n_done          = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale_limit <= PRESCALE_RESET;
            r_window_ticks   <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PRESCALE_LIMIT: r_prescale_limit <= i_cfg_data[PRESCALE_W-1:0];
                REG_WINDOW_TICKS:   r_window_ticks   <= i_cfg_data[WINDOW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fine_count    <= '0;
            r_coarse_count  <= '0;
            r_low_time      <= '0;
            r_high_time     <= '0;
            r_pedal_prev    <= 1'b0;
            r_hall_prev     <= 1'b0;
            r_pedal_run     <= '0;
            r_wheel_run     <= '0;
            r_tick_count    <= '0;
            r_pedal_latched <= '0;
            r_wheel_latched <= '0;
        end else if (w_accept) begin
            r_fine_count    <= n_fine_count;
            r_coarse_count  <= n_coarse_count;
            r_low_time      <= n_low_time;
            r_high_time     <= n_high_time;
            r_pedal_prev    <= i_pedal_level;
            r_hall_prev     <= i_hall_level;
            r_pedal_run     <= n_pedal_run;
            r_wheel_run     <= n_wheel_run;
            r_tick_count    <= n_tick_count;
            r_pedal_latched <= n_pedal_latched;
            r_wheel_latched <= n_wheel_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_done <= n_done;
        end
    end

    // The result fields always show the latched counts, which only change
    // when a sample is accepted, so they hold while the output is stalled.
    assign o_out_valid    = r_out_valid;
    assign o_pedal_result = r_pedal_latched;
    assign o_wheel_result = r_wheel_latched;
    assign o_window_done  = r_done;

endmodule

FILE: tb/pedal_cadence_and_wheel_pulse_counter_top_test.sv
// Self-checking testbench for the pedal cadence and wheel pulse counter.
// Depends on pcwpc_pkg and pedal_cadence_and_wheel_pulse_counter_top; it needs
// nothing else.
module pedal_cadence_and_wheel_pulse_counter_top_test;
    import pcwpc_pkg::*;

    // One sensor sample as it travels on the input channel, and the window
    // report that the block returns for it.
    typedef struct {
        logic pedal;
        logic hall;
        logic tick;
    } t_sensor_sample;

    typedef struct {
        t_count pedal;
        t_count wheel;
        logic   done;
    } t_window_report;

    // Every input of the block is known from time zero on.
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_PRESCALE_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_pedal  = 1'b0;
    logic                  in_hall   = 1'b0;
    logic                  in_tick   = 1'b0;
    logic                  out_stall = 1'b0;

    logic   in_stall;
    logic   out_valid;
    t_count pedal_result;
    t_count wheel_result;
    logic   window_done;

    pedal_cadence_and_wheel_pulse_counter_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_pedal_level  (in_pedal),
        .i_hall_level   (in_hall),
        .i_tick         (in_tick),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_pedal_result (pedal_result),
        .o_wheel_result (wheel_result),
        .o_window_done  (window_done)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Samples waiting for the driver, and reports the block still owes us.
    t_sensor_sample sample_queue[$];
    t_window_report report_queue[$];

    // Both counters change only at the rising edge (beats_taken) or in the
    // stimulus process (samples_queued), so the idle check made at the
    // falling edge never races the driver or the monitor.
    int unsigned samples_queued = 0;
    int unsigned beats_taken    = 0;
    int unsigned mismatches     = 0;

    // Set by the monitor when the input beat on the wires went in at the
    // last rising edge, so the driver may put up the next one.
    logic        last_taken = 1'b0;
    // When set, neither side inserts gaps or stalls.
    logic        quiet      = 1'b0;
    int unsigned send_pause = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    int unsigned hold_ask   = 0;
    int unsigned hold_seen  = 0;

    // Our own copy of the counter state and the two registers. It is stepped
    // once per accepted input beat, in acceptance order.
    t_time                cur_prescale      = PRESCALE_RESET;
    logic [WINDOW_W-1:0]  cur_window        = WINDOW_RESET;
    t_time                mdl_fine          = '0;
    t_time                mdl_coarse        = '0;
    t_time                mdl_low           = '0;
    t_time                mdl_high          = '0;
    logic                 mdl_pedal_prev    = 1'b0;
    logic                 mdl_hall_prev     = 1'b0;
    t_count               mdl_pedal_run     = '0;
    t_count               mdl_wheel_run     = '0;
    t_count               mdl_ticks         = '0;
    t_count               mdl_pedal_latched = '0;
    t_count               mdl_wheel_latched = '0;

    // Advances the cadence state by one sample and returns the report the
    // block must give for it. The order inside one sample matters: time
    // base first, then the pedal edge, then the hall edge, then the tick.
    function automatic t_window_report step_cadence(input t_sensor_sample s);
        t_window_report r;
        r.done = 1'b0;
        // The fine counter wraps at 16 bits on its own; with the limit at its
        // maximum it therefore never exceeds it and the coarse count stays put.
        mdl_fine = mdl_fine + 1'b1;
        if (mdl_fine > cur_prescale) begin
            mdl_coarse = mdl_coarse + 1'b1;
            mdl_fine   = '0;
        end
        // Any pedal edge stores the elapsed coarse time and restarts timing.
        // The run count only survives while the high phase lasts at least as
        // long as the low phase.
        if (s.pedal != mdl_pedal_prev) begin
            if (s.pedal) begin
                mdl_low = mdl_coarse;
            end else begin
                mdl_high = mdl_coarse;
            end
            mdl_fine   = '0;
            mdl_coarse = '0;
            if (mdl_high >= mdl_low) begin
                mdl_pedal_run = mdl_pedal_run + 1'b1;
            end else begin
                mdl_pedal_run = '0;
            end
        end
        mdl_pedal_prev = s.pedal;
        if (s.hall && !mdl_hall_prev) begin
            mdl_wheel_run = mdl_wheel_run + 1'b1;
        end
        mdl_hall_prev = s.hall;
        // A window of zero ticks closes on every tick, since the count is
        // already at least zero after the increment.
        if (s.tick) begin
            mdl_ticks = mdl_ticks + 1'b1;
            if (mdl_ticks >= cur_window) begin
                mdl_pedal_latched = mdl_pedal_run;
                mdl_wheel_latched = mdl_wheel_run;
                mdl_ticks         = '0;
                mdl_pedal_run     = '0;
                mdl_wheel_run     = '0;
                r.done            = 1'b1;
            end
        end
        r.pedal = mdl_pedal_latched;
        r.wheel = mdl_wheel_latched;
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_pause();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    // Monitor and scoreboard. All outputs of the block are read at the rising
    // edge, before the block's own register updates of that edge land. The
    // output beat is checked before the input beat of the same edge is
    // predicted, so a stray output can never match a fresh expectation.
    always @(posedge i_clk) begin
        t_window_report want;
        t_sensor_sample seen;
        last_taken = in_valid && !in_stall;
        if (i_rst_n) begin
            if (cfg_we) begin
                if (cfg_index == REG_PRESCALE_LIMIT) begin
                    cur_prescale = cfg_data;
                end else if (cfg_index == REG_WINDOW_TICKS) begin
                    cur_window = cfg_data[WINDOW_W-1:0];
                end
            end
            if (out_valid && !out_stall) begin
                if (report_queue.size() == 0) begin
                    flag_mismatch("result beat with no sample outstanding");
                end else begin
                    want = report_queue.pop_front();
                    if (pedal_result !== want.pedal) begin
                        flag_mismatch($sformatf("pedal_result expected %0d got %0d",
                                                want.pedal, pedal_result));
                    end
                    if (wheel_result !== want.wheel) begin
                        flag_mismatch($sformatf("wheel_result expected %0d got %0d",
                                                want.wheel, wheel_result));
                    end
                    if (window_done !== want.done) begin
                        flag_mismatch($sformatf("window_done expected %0b got %0b",
                                                want.done, window_done));
                    end
                end
            end
            if (last_taken) begin
                seen.pedal = in_pedal;
                seen.hall  = in_hall;
                seen.tick  = in_tick;
                report_queue.push_back(step_cadence(seen));
                beats_taken++;
            end
        end
    end

    // Input driver. A beat stays on the wires, unchanged, until it has been
    // taken; only then may a gap start or the next sample go up. Each branch
    // assigns in_valid once, so a back-to-back beat keeps valid high.
    always @(negedge i_clk) begin
        t_sensor_sample nxt;
        if (!in_valid || last_taken) begin
            if (send_pause > 0) begin
                in_valid <= 1'b0;
                send_pause--;
            end else if (sample_queue.size() > 0) begin
                nxt = sample_queue.pop_front();
                in_pedal   <= nxt.pedal;
                in_hall    <= nxt.hall;
                in_tick    <= nxt.tick;
                in_valid   <= 1'b1;
                send_pause = quiet ? 0 : pick_pause();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver. Random stall bursts, plus a long hold-off on request that
    // is counted here in cycles. During the hold-off the output register
    // stays full and the block has to stall its input.
    always @(negedge i_clk) begin
        if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 99) < 30) begin
            out_stall  <= 1'b1;
            stall_left = pick_pause();
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic queue_sample(input logic p, input logic h, input logic t);
        t_sensor_sample s;
        s.pedal = p;
        s.hall  = h;
        s.tick  = t;
        sample_queue.push_back(s);
        samples_queued++;
    endtask

    // Returns at a falling edge once every queued sample went in and every
    // report came back.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (beats_taken != samples_queued || report_queue.size() != 0);
    endtask

    // Registers are only touched with the block idle; a short pause after
    // the last report covers any work in flight.
    task automatic program_regs(input t_time prescale, input logic [WINDOW_W-1:0] window);
        wait_drained();
        repeat (2) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PRESCALE_LIMIT;
        cfg_data  <= prescale;
        @(negedge i_clk);
        cfg_index <= REG_WINDOW_TICKS;
        cfg_data  <= {{(CFG_DATA_W-WINDOW_W){1'b0}}, window};
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Pedal and hall square waves with random half periods, so the high and
    // low phases differ and the cadence count both grows and clears. About
    // one sample in ten is plain noise.
    task automatic queue_waveform(input int n, input int pedal_max, input int hall_max,
                                  input int tick_odds);
        int   pedal_left;
        int   hall_left;
        logic p;
        logic h;
        p          = 1'($urandom_range(0, 1));
        h          = 1'($urandom_range(0, 1));
        pedal_left = $urandom_range(1, pedal_max);
        hall_left  = $urandom_range(1, hall_max);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
            end else begin
                queue_sample(p, h, $urandom_range(1, tick_odds) == 1);
                pedal_left = pedal_left - 1;
                if (pedal_left == 0) begin
                    p          = !p;
                    pedal_left = $urandom_range(1, pedal_max);
                end
                hall_left = hall_left - 1;
                if (hall_left == 0) begin
                    h         = !h;
                    hall_left = $urandom_range(1, hall_max);
                end
            end
        end
    endtask

    initial begin
        int unsigned pick;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values: every combination of the three levels,
        // then a stretch of ordinary pedaling.
        for (int k = 0; k < 8; k++) begin
            queue_sample(k[0], k[1], k[2]);
        end
        for (int k = 7; k >= 0; k--) begin
            queue_sample(k[0], k[1], k[2]);
        end
        queue_waveform(200, 30, 10, 3);

        // Prescale limit zero steps the coarse count on every sample; a
        // window of zero ticks closes on every tick. Low for six samples and
        // high for two clears the cadence count; the reverse lets it grow.
        program_regs('0, '0);
        repeat (6) queue_sample(1'b0, 1'b0, 1'b0);
        repeat (2) queue_sample(1'b1, 1'b1, 1'b0);
        repeat (6) queue_sample(1'b0, 1'b0, 1'b1);
        repeat (6) queue_sample(1'b1, 1'b1, 1'b0);
        repeat (2) queue_sample(1'b0, 1'b0, 1'b1);
        queue_sample(1'b1, 1'b0, 1'b1);
        queue_waveform(150, 12, 6, 4);

        // Limit at its maximum: the coarse count never moves, so high and
        // low times stay equal and every edge counts. Toggling on every
        // sample over a wide window wraps both run counters past 255.
        program_regs('1, 8'd255);
        for (int k = 0; k < 600; k++) begin
            queue_sample(k[0], k[0], (k % 3) == 0);
        end
        repeat (60) queue_sample(1'b0, 1'b0, 1'b1);

        // Random pedaling under several settings, the extremes first. The
        // first setting also gets the long receiver hold-off.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: program_regs(16'd1, 8'd1);
                1: program_regs(16'd65534, 8'd255);
                5: begin
                    pick = $urandom_range(0, 65535);
                    program_regs(pick[15:0], 8'($urandom_range(1, 255)));
                end
                default: program_regs(16'($urandom_range(0, 7)), 8'($urandom_range(1, 20)));
            endcase
            quiet = (phase == 3);
            queue_waveform(140, 40, 12, $urandom_range(1, 5));
            if (phase == 0) begin
                hold_ask++;
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && report_queue.size() == 0) begin
            $display("** pedal_cadence_and_wheel_pulse_counter_top: PASSED **");
        end else begin
            $display("** pedal_cadence_and_wheel_pulse_counter_top: FAILED **");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run with every gap and stall
    // at its longest.
    initial begin
        #8000000;
        $display("** pedal_cadence_and_wheel_pulse_counter_top: FAILED **");
        $finish;
    end

endmodule
